// ===== rtl/core/acia_pkg.sv =====
// shared types, constants and the baud table of the serial adapter
package acia_pkg;

	localparam int FIFO_DEPTH = 1024;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam int CNT_W      = 23;
	localparam int TICK_W     = 15;
	localparam int FACTOR_W   = 8;
	localparam int Q_DEPTH    = 2;
	localparam int Q_AW       = $clog2(Q_DEPTH);
	localparam int Q_CW       = $clog2(Q_DEPTH + 1);
	localparam int CFG_AW     = 3;

	localparam logic CFG_IDX_FACTOR = 1'b0;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd1;

	localparam int ST_PE   = 0;
	localparam int ST_FE   = 1;
	localparam int ST_OVR  = 2;
	localparam int ST_RDRF = 3;
	localparam int ST_TDRE = 4;
	localparam int ST_IRQ  = 7;
	localparam int CMD_DTR = 0;
	localparam int CMD_RXIRQ_OFF = 1;

	localparam logic [7:0] STATUS_RESET    = 8'h10;
	localparam logic [7:0] SOFT_STATUS_MSK = 8'b1111_1011;
	localparam logic [7:0] SOFT_CMD_MSK    = 8'b1110_0000;
	localparam logic [7:0] RD_DATA_CLR_MSK = 8'hF0;
	localparam logic [7:0] IRQ_CLR_MSK     = 8'h7F;
	localparam logic [7:0] WR_DATA_SET     = 8'h90;

	typedef enum logic [2:0] {
		REQ_WRITE    = 3'd0,
		REQ_READ     = 3'd1,
		REQ_RX       = 3'd2,
		REQ_TICK     = 3'd3,
		REQ_HARD_RST = 3'd4
	} req_kind_t;

	typedef enum logic [1:0] {
		SEL_DATA   = 2'd0,
		SEL_STATUS = 2'd1,
		SEL_CMD    = 2'd2,
		SEL_CTRL   = 2'd3
	} reg_sel_t;

	typedef enum logic [3:0] {
		OP_NOP       = 4'd0,
		OP_WR_DATA   = 4'd1,
		OP_SOFT_RST  = 4'd2,
		OP_WR_CMD    = 4'd3,
		OP_WR_CTRL   = 4'd4,
		OP_RD_DATA   = 4'd5,
		OP_RD_STATUS = 4'd6,
		OP_RD_CMD    = 4'd7,
		OP_RD_CTRL   = 4'd8,
		OP_RX_BYTE   = 4'd9,
		OP_TICK      = 4'd10,
		OP_HARD_RST  = 4'd11
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
	} acia_op_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [TICK_W-1:0] baud_ticks(input logic [3:0] idx);
		logic [TICK_W-1:0] t;
		unique case (idx)
			4'd0:  t = 15'd9;
			4'd1:  t = 15'd20000;
			4'd2:  t = 15'd13333;
			4'd3:  t = 15'd9174;
			4'd4:  t = 15'd7463;
			4'd5:  t = 15'd6667;
			4'd6:  t = 15'd3333;
			4'd7:  t = 15'd1667;
			4'd8:  t = 15'd833;
			4'd9:  t = 15'd556;
			4'd10: t = 15'd417;
			4'd11: t = 15'd278;
			4'd12: t = 15'd208;
			4'd13: t = 15'd139;
			4'd14: t = 15'd104;
			4'd15: t = 15'd52;
			default: t = 15'd9;
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/core/acia_if.sv =====
// request and result channel interfaces of the serial adapter
interface acia_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [1:0] reg_select;
	logic [7:0] write_data;
	logic [7:0] rx_byte;

	modport source (output valid, req_type, reg_select, write_data, rx_byte, input ready);
	modport sink (input valid, req_type, reg_select, write_data, rx_byte, output ready);
endinterface

interface acia_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       read_valid;
	logic [7:0] tx_byte;
	logic       tx_valid;
	logic       irq_active;
	logic       receiving;
	logic       transmitting;
	logic       fifo_dropped;

	modport source (output valid, read_data, read_valid, tx_byte, tx_valid, irq_active,
		receiving, transmitting, fifo_dropped, input ready);
	modport sink (input valid, read_data, read_valid, tx_byte, tx_valid, irq_active,
		receiving, transmitting, fifo_dropped, output ready);
endinterface

// ===== rtl/core/acia_front.sv =====
// front end: accepts requests and decodes them into operations
module acia_front
	import acia_pkg::*;
(
	acia_req_if.sink   req,
	input  q_stat_t    q_stat,
	output logic       push,
	output acia_op_t   push_op
);

	assign req.ready = !q_stat.full;
	assign push      = req.valid && !q_stat.full;

	always_comb begin
		push_op.data = req.write_data;
		push_op.op   = OP_NOP;
		case (req.req_type)
			REQ_WRITE: begin
				unique case (req.reg_select)
					SEL_DATA:   push_op.op = OP_WR_DATA;
					SEL_STATUS: push_op.op = OP_SOFT_RST;
					SEL_CMD:    push_op.op = OP_WR_CMD;
					SEL_CTRL:   push_op.op = OP_WR_CTRL;
					default:    push_op.op = OP_NOP;
				endcase
			end
			REQ_READ: begin
				unique case (req.reg_select)
					SEL_DATA:   push_op.op = OP_RD_DATA;
					SEL_STATUS: push_op.op = OP_RD_STATUS;
					SEL_CMD:    push_op.op = OP_RD_CMD;
					SEL_CTRL:   push_op.op = OP_RD_CTRL;
					default:    push_op.op = OP_NOP;
				endcase
			end
			REQ_RX: begin
				push_op.op   = OP_RX_BYTE;
				push_op.data = req.rx_byte;
			end
			REQ_TICK:     push_op.op = OP_TICK;
			REQ_HARD_RST: push_op.op = OP_HARD_RST;
			default:      push_op.op = OP_NOP;
		endcase
	end

endmodule

// ===== rtl/core/acia_queue.sv =====
// short operation queue between front end and execution
module acia_queue
	import acia_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  q_ctl_t   ctl,
	input  acia_op_t push_op,
	output acia_op_t head_op,
	output q_stat_t  stat
);

	acia_op_t          entry_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [Q_CW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (count_q == Q_CW'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = ctl.push && !stat.full;
	assign do_pop     = ctl.pop && !stat.empty;
	assign head_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + Q_CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - Q_CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/acia_back.sv =====
// execution: registers, baud countdowns, receive fifo and result register
module acia_back
	import acia_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [FACTOR_W-1:0] factor,
	input  acia_op_t            head_op,
	input  q_stat_t             q_stat,
	output logic                pop,
	acia_rsp_if.source          rsp
);

	logic [7:0]         status_q, command_q, control_q, tx_hold_q, rx_hold_q;
	logic [CNT_W-1:0]   tx_cnt_q, rx_cnt_q;
	logic               tx_run_q, rx_run_q;
	logic [FIFO_AW-1:0] head_q, tail_q;
	logic [FIFO_CW-1:0] count_q;

	logic [7:0]         status_d, command_d, control_d, tx_hold_d, rx_hold_d;
	logic [CNT_W-1:0]   tx_cnt_d, rx_cnt_d;
	logic               tx_run_d, rx_run_d;
	logic [FIFO_AW-1:0] head_d, tail_d;
	logic [FIFO_CW-1:0] count_d;

	logic [7:0]         fifo_mem [FIFO_DEPTH];
	logic [7:0]         mem_rd_q;
	logic               byp_q;
	logic [7:0]         byp_data_q;
	logic [7:0]         head_data;
	logic               mem_we;

	logic [CNT_W-1:0]   delay;
	logic               exec;
	logic [7:0]         rd_d, txb_d;
	logic               rv_d, txv_d, drop_d;

	logic               out_valid_q;
	logic [7:0]         out_rd_q, out_txb_q;
	logic               out_rv_q, out_txv_q, out_irq_q, out_rx_q, out_tx_q, out_drop_q;

	assign exec      = !q_stat.empty && (!out_valid_q || rsp.ready);
	assign pop       = exec;
	assign delay     = CNT_W'(baud_ticks(control_q[3:0])) * CNT_W'(factor);
	assign head_data = byp_q ? byp_data_q : mem_rd_q;

	always_comb begin
		status_d  = status_q;
		command_d = command_q;
		control_d = control_q;
		tx_hold_d = tx_hold_q;
		rx_hold_d = rx_hold_q;
		tx_cnt_d  = tx_cnt_q;
		rx_cnt_d  = rx_cnt_q;
		tx_run_d  = tx_run_q;
		rx_run_d  = rx_run_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		mem_we    = 1'b0;
		rd_d      = '0;
		rv_d      = 1'b0;
		txb_d     = '0;
		txv_d     = 1'b0;
		drop_d    = 1'b0;
		if (exec) begin
			unique case (head_op.op)
				OP_WR_DATA: begin
					tx_hold_d = head_op.data;
					status_d  = status_q | WR_DATA_SET;
					if (!tx_run_q && command_q[CMD_DTR]) begin
						tx_run_d = 1'b1;
						tx_cnt_d = delay;
					end
				end
				OP_SOFT_RST: begin
					status_d  = status_q & SOFT_STATUS_MSK;
					command_d = command_q & SOFT_CMD_MSK;
				end
				OP_WR_CMD:  command_d = head_op.data;
				OP_WR_CTRL: control_d = head_op.data;
				OP_RD_DATA: begin
					rv_d     = 1'b1;
					rd_d     = rx_hold_q;
					status_d = status_q & RD_DATA_CLR_MSK;
				end
				OP_RD_STATUS: begin
					rv_d     = 1'b1;
					rd_d     = status_q;
					status_d = status_q & IRQ_CLR_MSK;
				end
				OP_RD_CMD: begin
					rv_d = 1'b1;
					rd_d = command_q;
				end
				OP_RD_CTRL: begin
					rv_d = 1'b1;
					rd_d = control_q;
				end
				OP_RX_BYTE: begin
					if (count_q == FIFO_CW'(FIFO_DEPTH)) begin
						drop_d = 1'b1;
					end else begin
						mem_we  = 1'b1;
						tail_d  = (tail_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
							: tail_q + FIFO_AW'(1);
						count_d = count_q + FIFO_CW'(1);
					end
					if (!rx_run_q) begin
						rx_run_d = 1'b1;
						rx_cnt_d = delay;
					end
				end
				OP_TICK: begin
					if (tx_run_q) begin
						if (tx_cnt_q <= CNT_W'(1)) begin
							tx_run_d = 1'b0;
							tx_cnt_d = '0;
							txv_d    = 1'b1;
							txb_d    = tx_hold_q;
						end else begin
							tx_cnt_d = tx_cnt_q - CNT_W'(1);
						end
					end
					if (rx_run_q) begin
						if (rx_cnt_q <= CNT_W'(1)) begin
							if (count_q == '0) begin
								rx_run_d = 1'b0;
							end else begin
								head_d  = (head_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0
									: head_q + FIFO_AW'(1);
								count_d = count_q - FIFO_CW'(1);
								if (status_q[ST_RDRF]) begin
									status_d[ST_OVR] = 1'b1;
								end else begin
									rx_hold_d         = head_data;
									status_d[ST_RDRF] = 1'b1;
									if (!command_q[CMD_RXIRQ_OFF]) begin
										status_d[ST_IRQ] = 1'b1;
									end
								end
								if (count_q != FIFO_CW'(1)) begin
									rx_cnt_d = delay;
								end else begin
									rx_run_d = 1'b0;
									rx_cnt_d = '0;
								end
							end
						end else begin
							rx_cnt_d = rx_cnt_q - CNT_W'(1);
						end
					end
				end
				OP_HARD_RST: begin
					status_d  = STATUS_RESET;
					command_d = '0;
					control_d = '0;
				end
				OP_NOP: ;
				default: ;
			endcase
		end
	end

	// receive fifo, read port follows the next head with write bypass
	always_ff @(posedge clk) begin
		if (mem_we) begin
			fifo_mem[tail_q] <= head_op.data;
		end
		mem_rd_q   <= fifo_mem[head_d];
		byp_data_q <= head_op.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q  <= STATUS_RESET;
			command_q <= '0;
			control_q <= '0;
			tx_hold_q <= '0;
			rx_hold_q <= '0;
			tx_cnt_q  <= '0;
			rx_cnt_q  <= '0;
			tx_run_q  <= 1'b0;
			rx_run_q  <= 1'b0;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			byp_q     <= 1'b0;
		end else begin
			status_q  <= status_d;
			command_q <= command_d;
			control_q <= control_d;
			tx_hold_q <= tx_hold_d;
			rx_hold_q <= rx_hold_d;
			tx_cnt_q  <= tx_cnt_d;
			rx_cnt_q  <= rx_cnt_d;
			tx_run_q  <= tx_run_d;
			rx_run_q  <= rx_run_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			byp_q     <= mem_we && (tail_q == head_d);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_rd_q   <= rd_d;
			out_rv_q   <= rv_d;
			out_txb_q  <= txb_d;
			out_txv_q  <= txv_d;
			out_irq_q  <= status_d[ST_IRQ];
			out_rx_q   <= rx_run_d;
			out_tx_q   <= tx_run_d;
			out_drop_q <= drop_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.read_data    = out_rd_q;
	assign rsp.read_valid   = out_rv_q;
	assign rsp.tx_byte      = out_txb_q;
	assign rsp.tx_valid     = out_txv_q;
	assign rsp.irq_active   = out_irq_q;
	assign rsp.receiving    = out_rx_q;
	assign rsp.transmitting = out_tx_q;
	assign rsp.fifo_dropped = out_drop_q;

endmodule

// ===== rtl/core/acia_serial_controller_core.sv =====
// top level of the serial adapter core with its configuration port
// One request is taken per clock cycle while the operation queue is not full; each gives exactly
// one result. The request is registered in the operation queue and its result in the result
// register. This two-entry queue sits between the request decoder and the execution stage, so
// the request side keeps moving while a result waits, until the queue is full. The baud countdown
// load is one table lookup times the delay factor. The 1024-byte receive fifo is one memory whose
// registered read port, with a write bypass, holds the fifo head byte; it needs no clearing after
// reset. The delay factor sits at configuration port addresses 0 to 3 and resets to 1.
module acia_serial_controller_core
	import acia_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	acia_req_if.sink          req,
	acia_rsp_if.source        rsp
);

	logic [FACTOR_W-1:0] factor_q;
	logic                cfg_wr;
	logic                q_push;
	logic                q_pop;
	q_ctl_t              q_ctl;
	q_stat_t             q_stat;
	acia_op_t            push_op;
	acia_op_t            head_op;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_FACTOR);
	assign prdata = (paddr[2] == CFG_IDX_FACTOR) ? {{(32 - FACTOR_W){1'b0}}, factor_q} : '0;
	assign q_ctl  = '{push: q_push, pop: q_pop};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
		end else if (cfg_wr) begin
			factor_q <= pwdata[FACTOR_W-1:0];
		end
	end

	acia_front u_front (
		.req     (req),
		.q_stat  (q_stat),
		.push    (q_push),
		.push_op (push_op)
	);

	acia_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (q_ctl),
		.push_op (push_op),
		.head_op (head_op),
		.stat    (q_stat)
	);

	acia_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.factor  (factor_q),
		.head_op (head_op),
		.q_stat  (q_stat),
		.pop     (q_pop),
		.rsp     (rsp)
	);

endmodule
